/* hw/rtl/sha1_stream_hasher_top_defines.svh */
// ----------------------------------------------------------------------------
// sha1_stream_hasher_top_defines.svh
// Assertion macros for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA1_STREAM_HASHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SHA1SH_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sha1sh: same-cycle check failed");
// next-cycle implication
`define SHA1SH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sha1sh: next-cycle check failed");
`else
`define SHA1SH_ASSERT_SAME(label, ante, cons)
`define SHA1SH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/sha1sh_pkg.sv */
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Types, constants and command codes shared by the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1sh_pkg;

  typedef logic [31:0] word_t;

  localparam word_t InitChain [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t RoundK0 = 32'h5A827999;
  localparam word_t RoundK1 = 32'h6ED9EBA1;
  localparam word_t RoundK2 = 32'h8F1BBCDC;
  localparam word_t RoundK3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [7:0] ZeroByte = 8'h00;

  localparam logic [5:0] FillFull = 6'd63;
  localparam logic [5:0] FillLen  = 6'd56;

  localparam logic [6:0] Round20   = 7'd20;
  localparam logic [6:0] Round40   = 7'd40;
  localparam logic [6:0] Round60   = 7'd60;
  localparam logic [6:0] RoundLast = 7'd79;

  localparam logic [2:0] WordLast = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MSG,
    OP_PAD80,
    OP_ZERO,
    OP_LEN,
    OP_LOAD,
    OP_ROUND,
    OP_ADD,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       out_load;
    logic [2:0] word_sel;
  } cmd_t;

  typedef struct packed {
    logic fill_full;
    logic fill_len;
    logic last_round;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/sha1sh_if.sv */
// ----------------------------------------------------------------------------
// sha1sh_if
// Valid/ready channels of the SHA-1 stream hasher: byte input, digest output.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_present;
  logic       is_last;

  modport source (output valid, output message_byte, output byte_present,
                  output is_last, input ready);
  modport sink   (input valid, input message_byte, input byte_present,
                  input is_last, output ready);
endinterface

interface sha1sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sha1_stream_hasher_top.sv */
// ----------------------------------------------------------------------------
// sha1_stream_hasher_top
// SHA-1 over a byte stream; emits the 160-bit digest as five 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   msg_i carries one item per transfer: message_byte, byte_present, is_last.
//   dig_o carries the digest, word 0 first, big-endian words, last_word on 4.
//   Byte items are absorbed back to back until the 64th byte of a block,
//   which starts a compression (load, 80 rounds at one per cycle, chain add)
//   during which msg_i.ready is low. After an item with is_last, the 0x80
//   byte and zero padding shift in one byte per cycle and the 64-bit bit
//   count as a whole; one or two compressions run in all, then the five words
//   leave through an output register, one per cycle while dig_o.ready is high.
//   A stalled receiver holds the readout; msg_i.ready returns once the
//   fifth word is loaded, so the next message may start while it waits.
//   An item with neither byte nor last mark is taken and has no effect.
//   Reset loads the initial chaining value and clears the byte count; after
//   each digest the block returns to that state by itself.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha1_stream_hasher_top_defines.svh"

module sha1_stream_hasher_top import sha1sh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sha1sh_in_if.sink    msg_i,
  sha1sh_out_if.source dig_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  sha1sh_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (msg_i.valid),
    .in_present_i (msg_i.byte_present),
    .in_last_i    (msg_i.is_last),
    .in_ready_o   (in_ready),
    .out_ready_i  (dig_o.ready),
    .out_valid_o  (out_valid),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  sha1sh_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .msg_byte_i    (msg_i.message_byte),
    .sts_o         (sts),
    .digest_word_o (dig_o.digest_word),
    .word_index_o  (dig_o.word_index),
    .last_word_o   (dig_o.last_word)
  );

  assign msg_i.ready = in_ready;
  assign dig_o.valid = out_valid;

  `SHA1SH_ASSERT_NEXT(a_last_busy, msg_i.valid && in_ready && msg_i.is_last, !in_ready)
  `SHA1SH_ASSERT_NEXT(a_round_add, cmd.op == OP_ROUND && sts.last_round, cmd.op == OP_ADD)
  `SHA1SH_ASSERT_SAME(a_last_word, out_valid && dig_o.last_word, dig_o.word_index == WordLast)
  `SHA1SH_ASSERT_NEXT(a_finish_idle, cmd.op == OP_FINISH, in_ready)

endmodule

`default_nettype wire

/* hw/rtl/sha1sh_ctrl.sv */
// ----------------------------------------------------------------------------
// sha1sh_ctrl
// Sequencer: byte intake, padding, compression rounds and digest readout.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1sh_ctrl import sha1sh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_present_i,
  input  logic in_last_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ZERO  = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_ADD   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  localparam logic [1:0] RetIdle = 2'd0;
  localparam logic [1:0] RetPad  = 2'd1;
  localparam logic [1:0] RetZero = 2'd2;
  localparam logic [1:0] RetEmit = 2'd3;

  logic [2:0] state_q, state_d;
  logic [1:0] ret_q, ret_d;
  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d         = state_q;
    ret_d           = ret_q;
    idx_d           = idx_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    cmd_o.op        = OP_NONE;
    cmd_o.out_load  = 1'b0;
    cmd_o.word_sel  = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_present_i) begin
            cmd_o.op = OP_MSG;
          end
          if (in_present_i && sts_i.fill_full) begin
            state_d = S_LOAD;
            ret_d   = in_last_i ? RetPad : RetIdle;
          end else if (in_last_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd_o.op = OP_PAD80;
        if (sts_i.fill_full) begin
          state_d = S_LOAD;
          ret_d   = RetZero;
        end else begin
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        if (sts_i.fill_len) begin
          state_d = S_LEN;
        end else begin
          cmd_o.op = OP_ZERO;
          if (sts_i.fill_full) begin
            state_d = S_LOAD;
            ret_d   = RetZero;
          end
        end
      end
      S_LEN: begin
        cmd_o.op = OP_LEN;
        state_d  = S_LOAD;
        ret_d    = RetEmit;
      end
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        state_d  = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.op = OP_ROUND;
        if (sts_i.last_round) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.op = OP_ADD;
        case (ret_q)
          RetIdle: state_d = S_IDLE;
          RetPad:  state_d = S_PAD;
          RetZero: state_d = S_ZERO;
          RetEmit: begin
            idx_d   = 3'd0;
            state_d = S_EMIT;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          if (idx_q == WordLast) begin
            cmd_o.op = OP_FINISH;
            state_d  = S_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= RetIdle;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sha1sh_datapath.sv */
// ----------------------------------------------------------------------------
// sha1sh_datapath
// Block shift buffer, message schedule, round logic, chaining words, counters.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1sh_datapath import sha1sh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [7:0]  msg_byte_i,
  output sts_t        sts_o,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  word_t        chain_q [5];
  word_t        work_q  [5];
  logic [511:0] blk_q, blk_d;
  logic [60:0]  cnt_q;
  logic [5:0]   fill_q;
  logic [6:0]   round_q;
  word_t        out_word_q;
  logic [2:0]   out_idx_q;
  logic         out_last_q;

  word_t w0, w2, w8, w13, wx, wnew;
  word_t f_val, k_val, t_val;

  // window slot j holds w[t+j]
  assign w0   = blk_q[511:480];
  assign w2   = blk_q[447:416];
  assign w8   = blk_q[255:224];
  assign w13  = blk_q[95:64];
  assign wx   = w13 ^ w8 ^ w2 ^ w0;
  assign wnew = {wx[30:0], wx[31]};

  always_comb begin
    if (round_q < Round20) begin
      f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      k_val = RoundK0;
    end else if (round_q < Round40) begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = RoundK1;
    end else if (round_q < Round60) begin
      f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) |
              (work_q[2] & work_q[3]);
      k_val = RoundK2;
    end else begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = RoundK3;
    end
  end

  assign t_val = {work_q[0][26:0], work_q[0][31:27]} + f_val + work_q[4] + k_val + w0;

  always_comb begin
    case (cmd_i.op)
      OP_MSG:   blk_d = {blk_q[503:0], msg_byte_i};
      OP_PAD80: blk_d = {blk_q[503:0], PadByte};
      OP_ZERO:  blk_d = {blk_q[503:0], ZeroByte};
      OP_LEN:   blk_d = {blk_q[447:0], cnt_q, 3'b000};
      OP_ROUND: blk_d = {blk_q[479:0], wnew};
      default:  blk_d = blk_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    if (cmd_i.out_load) begin
      out_word_q <= chain_q[cmd_i.word_sel];
      out_idx_q  <= cmd_i.word_sel;
      out_last_q <= (cmd_i.word_sel == WordLast);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        chain_q[i] <= InitChain[i];
        work_q[i]  <= '0;
      end
      cnt_q   <= '0;
      fill_q  <= '0;
      round_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_MSG: begin
          cnt_q  <= cnt_q + 61'd1;
          fill_q <= fill_q + 6'd1;
        end
        OP_PAD80, OP_ZERO: begin
          fill_q <= fill_q + 6'd1;
        end
        OP_LEN: begin
          fill_q <= '0;
        end
        OP_LOAD: begin
          for (int i = 0; i < 5; i++) begin
            work_q[i] <= chain_q[i];
          end
          round_q <= '0;
        end
        OP_ROUND: begin
          work_q[0] <= t_val;
          work_q[1] <= work_q[0];
          work_q[2] <= {work_q[1][1:0], work_q[1][31:2]};
          work_q[3] <= work_q[2];
          work_q[4] <= work_q[3];
          round_q   <= (round_q == RoundLast) ? 7'd0 : round_q + 7'd1;
        end
        OP_ADD: begin
          for (int i = 0; i < 5; i++) begin
            chain_q[i] <= chain_q[i] + work_q[i];
          end
        end
        OP_FINISH: begin
          for (int i = 0; i < 5; i++) begin
            chain_q[i] <= InitChain[i];
          end
          cnt_q  <= '0;
          fill_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign sts_o.fill_full  = (fill_q == FillFull);
  assign sts_o.fill_len   = (fill_q == FillLen);
  assign sts_o.last_round = (round_q == RoundLast);

  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign last_word_o   = out_last_q;

endmodule

`default_nettype wire
